// File: rtl/gregorian_date_arithmetic_unit_assert.svh
// Assertion macros for the date arithmetic unit
`ifndef GREGORIAN_DATE_ARITHMETIC_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_UNIT_ASSERT_SVH

`define GDA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define GDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gda_pkg.sv
package gda_pkg;

    localparam int unsigned MaxYear = 9999;

    localparam int unsigned YearW   = 14;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned OffW    = 23;
    localparam int unsigned SerW    = 26;

    localparam logic [SerW-1:0] Days400 = SerW'(146097);
    localparam logic [SerW-1:0] Days100 = SerW'(36524);
    localparam logic [SerW-1:0] Days4   = SerW'(1461);
    localparam logic [SerW-1:0] Days1   = SerW'(365);

    localparam logic CmdAdd  = 1'b0;
    localparam logic CmdDiff = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_TOSA  = 8'b00000010,
        ST_TOSB  = 8'b00000100,
        ST_ADD   = 8'b00001000,
        ST_YEARS = 8'b00010000,
        ST_MONTH = 8'b00100000,
        ST_DIFF  = 8'b01000000,
        ST_DONE  = 8'b10000000
    } gda_state_t;

    typedef struct packed {
        logic load;
        logic to_serial_a;
        logic to_serial_b;
        logic add_offset;
        logic year_step;
        logic month_step;
        logic diff;
        logic done;
    } gda_cmd_t;

    typedef struct packed {
        logic is_diff;
        logic serial_done;
        logic year_done;
        logic month_done;
    } gda_status_t;

    // floor(x / 25) by reciprocal multiply, exact for any 14-bit x
    function automatic logic [YearW-1:0] div25(input logic [YearW-1:0] x);
        logic [YearW+12:0] prod;
        prod = (YearW+13)'(x) * (YearW+13)'(5243);
        div25 = YearW'(prod >> 17);
    endfunction

    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic by25;
        by25 = (div25(y) * YearW'(25)) == y;
        is_leap = (y[1:0] == 2'b00) && (!by25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DayW-1:0] month_days(input logic [YearW-1:0] y,
                                                   input logic [MonthW-1:0] m);
        logic [DayW-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            4'd2: d = is_leap(y) ? 5'd29 : 5'd28;
            default: d = 5'd0;
        endcase
        month_days = d;
    endfunction

    function automatic logic [SerW-1:0] days_before_year(input logic [YearW:0] y);
        logic [YearW:0] p;
        p = y - 1'b1;
        days_before_year = SerW'(p) * SerW'(365) + SerW'(p >> 2)
                         - SerW'(div25(YearW'(p >> 2))) + SerW'(div25(YearW'(p >> 4)));
    endfunction

    localparam logic [SerW-1:0] SerLimit = days_before_year((YearW+1)'(MaxYear + 1));

endpackage

// File: rtl/gda_ctrl.sv
module gda_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gda_pkg::gda_status_t status,
    output gda_pkg::gda_cmd_t    cmd,
    output logic                busy
);

    gda_pkg::gda_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = gda_pkg::ST_TOSA;
                end
            end
            gda_pkg::ST_TOSA:
            begin
                cmd.to_serial_a = 1'b1;
                if (status.serial_done)
                begin
                    state_next = gda_pkg::ST_TOSB;
                end
            end
            gda_pkg::ST_TOSB:
            begin
                cmd.to_serial_b = 1'b1;
                if (status.serial_done)
                begin
                    state_next = status.is_diff ? gda_pkg::ST_DIFF : gda_pkg::ST_ADD;
                end
            end
            gda_pkg::ST_ADD:
            begin
                cmd.add_offset = 1'b1;
                state_next = gda_pkg::ST_YEARS;
            end
            gda_pkg::ST_YEARS:
            begin
                cmd.year_step = 1'b1;
                if (status.year_done)
                begin
                    state_next = gda_pkg::ST_MONTH;
                end
            end
            gda_pkg::ST_MONTH:
            begin
                cmd.month_step = 1'b1;
                if (status.month_done)
                begin
                    state_next = gda_pkg::ST_DONE;
                end
            end
            gda_pkg::ST_DIFF:
            begin
                cmd.diff = 1'b1;
                state_next = gda_pkg::ST_DONE;
            end
            gda_pkg::ST_DONE:
            begin
                cmd.done = 1'b1;
                state_next = gda_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != gda_pkg::ST_IDLE);

endmodule

// File: rtl/gda_datapath.sv
module gda_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  gda_pkg::gda_cmd_t             cmd,
    output gda_pkg::gda_status_t          status,
    input  logic                          cmd_in,
    input  logic [gda_pkg::YearW-1:0]     year_a,
    input  logic [gda_pkg::MonthW-1:0]    month_a,
    input  logic [gda_pkg::DayW-1:0]      day_a,
    input  logic [gda_pkg::YearW-1:0]     year_b,
    input  logic [gda_pkg::MonthW-1:0]    month_b,
    input  logic [gda_pkg::DayW-1:0]      day_b,
    input  logic signed [gda_pkg::OffW-1:0] offset,
    output logic                          done,
    output logic [gda_pkg::YearW-1:0]     res_year,
    output logic [gda_pkg::MonthW-1:0]    res_month,
    output logic [gda_pkg::DayW-1:0]      res_day,
    output logic signed [gda_pkg::OffW-1:0] day_difference,
    output logic                          a_after_b,
    output logic                          dates_equal,
    output logic                          a_was_valid,
    output logic                          b_was_valid,
    output logic                          out_of_range
);

    localparam int unsigned SW = gda_pkg::SerW;
    localparam int unsigned NW = SW + 1;
    localparam int unsigned DayW = gda_pkg::DayW;

    logic                          op_reg;
    logic [gda_pkg::YearW-1:0]     yb_reg, cy_reg, ry_reg;
    logic [gda_pkg::MonthW-1:0]    mb_reg, cm_reg, rm_reg;
    logic [gda_pkg::DayW-1:0]      db_reg, cd_reg;
    logic signed [gda_pkg::OffW-1:0] off_reg;
    logic                          va_reg, vb_reg;
    logic [gda_pkg::MonthW-1:0]    k_reg;
    logic [SW-1:0]                 acc_reg, sa_reg, sb_reg;
    logic signed [NW-1:0]          n_reg;
    logic                          oor_reg;
    logic signed [NW-1:0]          diff_reg;
    logic [1:0]                    phase_reg;
    logic                          done_reg;
    logic [2:0]                    cnt_reg;

    logic va_c, vb_c;
    logic [gda_pkg::DayW-1:0] mlen_k, mlen_r;
    logic [SW-1:0] step;
    logic [SW-1:0] r_u;
    logic signed [NW-1:0] sum_n, diff_n;
    logic year_go;
    logic signed [gda_pkg::OffW-1:0] diff_sat;

    assign va_c = (year_a != '0) && (day_a != '0) && (day_a <= gda_pkg::month_days(year_a, month_a));
    assign vb_c = (year_b != '0) && (day_b != '0) && (day_b <= gda_pkg::month_days(year_b, month_b));
    assign mlen_k = gda_pkg::month_days(cy_reg, k_reg);
    assign mlen_r = gda_pkg::month_days(ry_reg, rm_reg);
    assign r_u = SW'(n_reg);
    assign sum_n = $signed({1'b0, sa_reg}) + NW'(off_reg);
    assign diff_n = $signed({1'b0, sa_reg}) - $signed({1'b0, sb_reg});

    always_comb
    begin
        case (phase_reg)
            2'd0: step = gda_pkg::Days400;
            2'd1: step = gda_pkg::Days100;
            2'd2: step = gda_pkg::Days4;
            default: step = gda_pkg::Days1;
        endcase
    end

    assign year_go = (r_u >= step) && !(phase_reg == 2'd1 && cnt_reg == 3'd3)
                   && !(phase_reg == 2'd3 && cnt_reg == 3'd3);

    assign status.is_diff = op_reg;
    assign status.serial_done = (k_reg >= cm_reg);
    assign status.year_done = (phase_reg == 2'd3) && !year_go;
    assign status.month_done = (rm_reg == 4'd12) || (r_u < SW'(mlen_r));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= cmd_in;
            va_reg <= va_c;
            vb_reg <= vb_c;
            yb_reg <= vb_c ? year_b : 14'd1;
            mb_reg <= vb_c ? month_b : 4'd1;
            db_reg <= vb_c ? day_b : 5'd1;
            off_reg <= offset;
            cy_reg <= va_c ? year_a : 14'd1;
            cm_reg <= va_c ? month_a : 4'd1;
            cd_reg <= va_c ? day_a : 5'd1;
            acc_reg <= va_c ? gda_pkg::days_before_year({1'b0, year_a}) : '0;
            k_reg <= 4'd1;
        end
        else if (cmd.to_serial_a || cmd.to_serial_b)
        begin
            if (k_reg < cm_reg)
            begin
                acc_reg <= acc_reg + SW'(mlen_k);
                k_reg <= k_reg + 4'd1;
            end
            else
            begin
                if (cmd.to_serial_a)
                begin
                    sa_reg <= acc_reg + SW'(cd_reg) - SW'(1);
                    cy_reg <= yb_reg;
                    cm_reg <= mb_reg;
                    cd_reg <= db_reg;
                    acc_reg <= gda_pkg::days_before_year({1'b0, yb_reg});
                    k_reg <= 4'd1;
                end
                else
                begin
                    sb_reg <= acc_reg + SW'(cd_reg) - SW'(1);
                end
            end
        end
        else if (cmd.add_offset)
        begin
            n_reg <= sum_n;
            oor_reg <= sum_n[NW-1] || (SW'(sum_n) >= gda_pkg::SerLimit);
            ry_reg <= 14'd1;
            phase_reg <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else if (cmd.year_step)
        begin
            if (oor_reg)
            begin
                phase_reg <= 2'd3;
                cnt_reg <= 3'd3;
            end
            else if (year_go)
            begin
                n_reg <= NW'(r_u - step);
                cnt_reg <= cnt_reg + 3'd1;
                case (phase_reg)
                    2'd0: ry_reg <= ry_reg + 14'd400;
                    2'd1: ry_reg <= ry_reg + 14'd100;
                    2'd2: ry_reg <= ry_reg + 14'd4;
                    default: ry_reg <= ry_reg + 14'd1;
                endcase
            end
            else if (phase_reg != 2'd3)
            begin
                phase_reg <= phase_reg + 2'd1;
                cnt_reg <= 3'd0;
            end
            rm_reg <= 4'd1;
        end
        else if (cmd.month_step)
        begin
            if (!status.month_done)
            begin
                n_reg <= NW'(r_u - SW'(mlen_r));
                rm_reg <= rm_reg + 4'd1;
            end
        end
        else if (cmd.diff)
        begin
            diff_reg <= diff_n;
            oor_reg <= (diff_n > NW'(4194303)) || (diff_n < -NW'(4194304));
        end
    end

    always_comb
    begin
        if (diff_reg > NW'(4194303))
        begin
            diff_sat = 23'sh3FFFFF;
        end
        else if (diff_reg < -NW'(4194304))
        begin
            diff_sat = 23'sh400000;
        end
        else
        begin
            diff_sat = diff_reg[gda_pkg::OffW-1:0];
        end
    end

    assign done = done_reg;
    assign res_year = (op_reg == gda_pkg::CmdDiff) ? '0 : (oor_reg ? 14'd1 : ry_reg);
    assign res_month = (op_reg == gda_pkg::CmdDiff) ? '0 : (oor_reg ? 4'd1 : rm_reg);
    assign res_day = (op_reg == gda_pkg::CmdDiff) ? '0
                   : (oor_reg ? 5'd1 : DayW'(r_u) + 5'd1);
    assign day_difference = (op_reg == gda_pkg::CmdDiff) ? diff_sat : '0;
    assign a_after_b = sa_reg > sb_reg;
    assign dates_equal = sa_reg == sb_reg;
    assign a_was_valid = va_reg;
    assign b_was_valid = vb_reg;
    assign out_of_range = oor_reg;

endmodule

// File: rtl/gregorian_date_arithmetic_unit.sv
// Gregorian date unit: hold start high until busy is low to load one item; the result appears
// with done high for exactly one cycle and must be captured then, since it cannot be stalled.
// An item runs from the accepting edge to the edge that takes its result, and the next item
// can be accepted on that same edge. Each date is converted to a day number one month per
// cycle. A difference then subtracts the two day numbers, finishes and raises done. An offset
// add forms the sum, walks the years in 400-, 100-, 4- and 1-year blocks, stepping to each
// smaller block size in turn (out of range skips the walk), walks the months one per cycle,
// finishes and raises done.
`include "gregorian_date_arithmetic_unit_assert.svh"
module gregorian_date_arithmetic_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          cmd,
    input  logic [gda_pkg::YearW-1:0]     year_a,
    input  logic [gda_pkg::MonthW-1:0]    month_a,
    input  logic [gda_pkg::DayW-1:0]      day_a,
    input  logic [gda_pkg::YearW-1:0]     year_b,
    input  logic [gda_pkg::MonthW-1:0]    month_b,
    input  logic [gda_pkg::DayW-1:0]      day_b,
    input  logic signed [gda_pkg::OffW-1:0] offset,
    output logic [gda_pkg::YearW-1:0]     res_year,
    output logic [gda_pkg::MonthW-1:0]    res_month,
    output logic [gda_pkg::DayW-1:0]      res_day,
    output logic signed [gda_pkg::OffW-1:0] day_difference,
    output logic                          a_after_b,
    output logic                          dates_equal,
    output logic                          a_was_valid,
    output logic                          b_was_valid,
    output logic                          out_of_range
);

    gda_pkg::gda_cmd_t    ctl;
    gda_pkg::gda_status_t sts;

    gda_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (sts),
        .cmd    (ctl),
        .busy   (busy)
    );

    gda_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl),
        .status         (sts),
        .cmd_in         (cmd),
        .year_a         (year_a),
        .month_a        (month_a),
        .day_a          (day_a),
        .year_b         (year_b),
        .month_b        (month_b),
        .day_b          (day_b),
        .offset         (offset),
        .done           (done),
        .res_year       (res_year),
        .res_month      (res_month),
        .res_day        (res_day),
        .day_difference (day_difference),
        .a_after_b      (a_after_b),
        .dates_equal    (dates_equal),
        .a_was_valid    (a_was_valid),
        .b_was_valid    (b_was_valid),
        .out_of_range   (out_of_range)
    );

    `GDA_ASSERT_NEXT(a_done_one, clk, rst_n, done, !done, "done held longer than one cycle")
    `GDA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "item not taken")
    `GDA_ASSERT_IMPL(a_order, clk, rst_n, done, !(a_after_b && dates_equal), "order flags clash")

endmodule
